// File: rtl/cfr_pkg.sv
// cfr_pkg: shared types and constants of the checksum frame receiver
// no dependencies; imported by cfr_core, cfr_out_buf, the top level and the test bench

package cfr_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int COUNT_W = 4;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START = 2'd1;

  localparam logic [BYTE_W-1:0] HEAD_RESET  = 8'hFF;
  localparam logic [BYTE_W-1:0] START_RESET = 8'h02;

  // receiver phases
  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;
  localparam logic [1:0] PH_CHECK = 2'd3;

  // body layout: two records of id byte plus four data bytes
  localparam logic [COUNT_W-1:0] BODY_LAST  = 4'd9;
  localparam logic [COUNT_W-1:0] RECORD_LEN = 4'd5;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      data;
  } cfg_t;

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
  } res_t;

endpackage

// File: rtl/cfr_core.sv
// cfr_core: frame hunting, record assembly and checksum compare, one byte per cycle while in_fire is high
// depends on cfr_pkg

module cfr_core (
  input  logic                  clk,
  input  logic                  rst,
  input  cfr_pkg::cfg_t         cfg,
  input  logic                  in_fire,
  input  logic [7:0]            rx_byte,
  output logic                  res_valid,
  output cfr_pkg::res_t         res
);
  import cfr_pkg::*;

  logic [BYTE_W-1:0]  head_value, start_value;
  logic [1:0]         phase, phase_next;
  logic [COUNT_W-1:0] body_count, body_count_next;
  logic [BYTE_W-1:0]  running_sum, running_sum_next;
  logic [BYTE_W-1:0]  record_slot, record_slot_next;
  logic [WORD_W-1:0]  frame_words [2];
  logic [WORD_W-1:0]  frame_words_next [2];
  logic [WORD_W-1:0]  held_words [2];
  logic [WORD_W-1:0]  held_words_next [2];
  logic [COUNT_W-1:0] pos_full;
  logic [2:0]         pos;
  logic               ok;
  logic [BYTE_W-1:0]  sum_plus;

  // position inside the current record
  assign pos_full = (body_count >= RECORD_LEN) ? body_count - RECORD_LEN : body_count;
  assign pos      = pos_full[2:0];
  assign sum_plus = running_sum + rx_byte;
  assign ok       = (rx_byte == running_sum);

  always_comb begin
    phase_next          = phase;
    body_count_next     = body_count;
    running_sum_next    = running_sum;
    record_slot_next    = record_slot;
    frame_words_next[0] = frame_words[0];
    frame_words_next[1] = frame_words[1];
    held_words_next[0]  = held_words[0];
    held_words_next[1]  = held_words[1];
    res_valid           = 1'b0;
    if (in_fire) begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == head_value) begin
            running_sum_next = rx_byte;
            phase_next       = PH_START;
          end
        end
        PH_START: begin
          if (rx_byte == start_value) begin
            running_sum_next = sum_plus;
            body_count_next  = '0;
            phase_next       = PH_BODY;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_BODY: begin
          running_sum_next = sum_plus;
          if (pos == 3'd0) begin
            record_slot_next = rx_byte;
          end else if (record_slot <= 8'd1) begin
            // big-endian lanes, first data byte is the top lane
            case (pos)
              3'd1:    frame_words_next[record_slot[0]][31:24] = rx_byte;
              3'd2:    frame_words_next[record_slot[0]][23:16] = rx_byte;
              3'd3:    frame_words_next[record_slot[0]][15:8]  = rx_byte;
              3'd4:    frame_words_next[record_slot[0]][7:0]   = rx_byte;
              default: ;
            endcase
          end
          if (body_count == BODY_LAST) begin
            body_count_next = '0;
            phase_next      = PH_CHECK;
          end else begin
            body_count_next = body_count + 4'd1;
          end
        end
        default: begin
          if (ok) begin
            held_words_next[0] = frame_words[0];
            held_words_next[1] = frame_words[1];
          end
          phase_next      = PH_HUNT;
          body_count_next = '0;
          res_valid       = 1'b1;
        end
      endcase
    end
  end

  assign res.ok = ok;
  assign res.w0 = held_words_next[0];
  assign res.w1 = held_words_next[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      head_value     <= HEAD_RESET;
      start_value    <= START_RESET;
      phase          <= PH_HUNT;
      body_count     <= '0;
      running_sum    <= '0;
      record_slot    <= '0;
      frame_words[0] <= '0;
      frame_words[1] <= '0;
      held_words[0]  <= '0;
      held_words[1]  <= '0;
    end else begin
      if (cfg.we && cfg.index == REG_HEAD) begin
        head_value <= cfg.data;
      end
      if (cfg.we && cfg.index == REG_START) begin
        start_value <= cfg.data;
      end
      phase          <= phase_next;
      body_count     <= body_count_next;
      running_sum    <= running_sum_next;
      record_slot    <= record_slot_next;
      frame_words[0] <= frame_words_next[0];
      frame_words[1] <= frame_words_next[1];
      held_words[0]  <= held_words_next[0];
      held_words[1]  <= held_words_next[1];
    end
  end

endmodule

// File: rtl/cfr_out_buf.sv
// cfr_out_buf: result register with one skid entry behind it
// depends on cfr_pkg

module cfr_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cfr_pkg::res_t res_in,
  input  logic          out_stall,
  output logic          out_valid,
  output cfr_pkg::res_t res_out,
  output logic          full
);
  import cfr_pkg::*;

  logic main_valid, skid_valid;
  res_t main, skid;
  logic pop;

  assign pop       = main_valid && !out_stall;
  assign out_valid = main_valid;
  assign res_out   = main;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= push;
      end else begin
        main_valid <= push;
      end
    end else if (!main_valid) begin
      main_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main <= skid;
        if (push) begin
          skid <= res_in;
        end
      end else if (push) begin
        main <= res_in;
      end
    end else if (!main_valid) begin
      if (push) begin
        main <= res_in;
      end
    end else if (push) begin
      skid <= res_in;
    end
  end

endmodule

// File: rtl/checksum_frame_receiver_top.sv
// checksum_frame_receiver_top: top level of the byte frame receiver
// depends on cfr_pkg, cfr_core and cfr_out_buf

// One received byte is taken per item, one item per clock cycle while in_stall
// is low. Each accepted byte updates the deframer state in the cycle it is
// taken, so the block runs at a full byte per cycle when not stalled; the
// per-byte update (one 8-bit add and compare) sets that figure. A frame is a
// head byte, the start byte, two records of an id byte plus a big-endian
// 32-bit word, and a checksum byte equal to the 8-bit sum of all earlier
// frame bytes. Exactly one result is produced per checksum byte and
// registered in the output buffer: frame_ok and the two held words, which
// change only on a checksum match. A record with an id above 1 is summed but
// not stored. Results sit in an output register backed by one skid entry, so
// input keeps flowing while a result waits; in_stall rises only when both
// entries are full. Configuration (head_value at index 0, start_value at
// index 1) is written on cfg_we and should be written while the block is idle.

module checksum_frame_receiver_top (
  input  logic                            clk,
  input  logic                            rst,
  // configuration port
  input  logic                            cfg_we,
  input  logic [cfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            frame_ok,
  output logic [31:0]                     word_zero,
  output logic [31:0]                     word_one
);
  import cfr_pkg::*;

  cfg_t cfg;
  res_t core_res, buf_res;
  logic core_res_valid;
  logic in_fire;
  logic buf_full;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // stall only when no room is left for a result
  assign in_stall = buf_full;
  assign in_fire  = in_valid && !in_stall;

  cfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .rx_byte   (rx_byte),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  cfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (core_res_valid),
    .res_in    (core_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (buf_res),
    .full      (buf_full)
  );

  assign frame_ok  = buf_res.ok;
  assign word_zero = buf_res.w0;
  assign word_one  = buf_res.w1;

endmodule

// File: rtl/cfr_checker.sv
// cfr_checker: port-level checks of the checksum frame receiver
// depends on checksum_frame_receiver_top, attached by bind

module cfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        frame_ok,
  input logic [31:0] word_zero,
  input logic [31:0] word_one
);

  logic [31:0] last_w0, last_w1;

  // words of the last delivered item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_w0 <= '0;
      last_w1 <= '0;
    end else if (out_valid && !out_stall) begin
      last_w0 <= word_zero;
      last_w1 <= word_one;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_ok)
      && $stable(word_zero) && $stable(word_one))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_rise_needs_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an accepted item");

  a_mismatch_keeps_words: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_ok |-> word_zero == last_w0 && word_one == last_w1)
    else $error("held words changed on checksum mismatch");

endmodule

bind checksum_frame_receiver_top cfr_checker u_cfr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .frame_ok  (frame_ok),
  .word_zero (word_zero),
  .word_one  (word_one)
);

// File: tb/sv/checksum_frame_receiver_top_test.sv
// checksum_frame_receiver_top_test: self-checking bench for the byte frame receiver
// depends on cfr_pkg and checksum_frame_receiver_top; drives bytes, checks frame results
// against a built-in deframer model, random idling on both channels

module checksum_frame_receiver_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cfr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;   // long result-side hold-off, fills the output buffer
  localparam int PHASE_BYTES = 255;   // random bytes per register setting
  localparam int NUM_SETTINGS = 6;
  localparam int DIR_LEN = 28;

  // directed table: a wrong start byte that is itself the head value, a frame whose
  // checksum is one off (writes slot 1, drops an id above one), then a good frame
  // that only writes slot 0 and drops an id of two, so slot 1 keeps the earlier word
  localparam logic [7:0] DIR_BYTES [DIR_LEN] = '{
    8'hFF, 8'hFF,
    8'hFF, 8'h02, 8'h01, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h3A,
    8'hFF, 8'h02, 8'h00, 8'h80, 8'h00, 8'h00, 8'h01, 8'h02, 8'h12, 8'h34, 8'h56, 8'h78,
    8'h98
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_HEAD;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        frame_ok;
  logic [31:0] word_zero;
  logic [31:0] word_one;

  checksum_frame_receiver_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .frame_ok  (frame_ok),
    .word_zero (word_zero),
    .word_one  (word_one)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // deframer model state, a private copy next to the block's own
  logic [7:0]  head_cfg = HEAD_RESET;
  logic [7:0]  start_cfg = START_RESET;
  logic [1:0]  rx_phase = PH_HUNT;
  int          body_cnt = 0;
  logic [7:0]  frame_sum = 8'h00;
  logic [7:0]  rec_id = 8'h00;
  logic [31:0] asm_word [2] = '{32'h0, 32'h0};
  logic [31:0] held_word [2] = '{32'h0, 32'h0};

  res_t pending_results [$];
  res_t typed_result [int];
  res_t got_front;

  int errors = 0;
  int results_checked = 0;
  int frames_matched = 0;
  int bytes_sent = 0;
  int in_stall_cycles = 0;
  int cycle_cnt = 0;
  bit idle_en = 1'b0;
  bit hold_req = 1'b0;

  // one received byte through the deframer; returns 1 when it closes a frame
  function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
    int lane;
    bit match;
    r = '0;
    case (rx_phase)
      PH_HUNT: begin
        if (b == head_cfg) begin
          frame_sum = b;
          rx_phase = PH_START;
        end
      end
      PH_START: begin
        // a wrong start byte is swallowed, not rechecked as a head
        if (b == start_cfg) begin
          frame_sum = frame_sum + b;
          body_cnt = 0;
          rx_phase = PH_BODY;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_BODY: begin
        frame_sum = frame_sum + b;
        lane = body_cnt % 5;
        if (lane == 0) rec_id = b;
        else if (rec_id <= 8'd1) asm_word[rec_id[0]][(4 - lane) * 8 +: 8] = b;
        body_cnt++;
        if (body_cnt == 10) begin
          body_cnt = 0;
          rx_phase = PH_CHECK;
        end
      end
      default: begin
        match = (b == frame_sum);
        if (match) held_word = asm_word;
        rx_phase = PH_HUNT;
        body_cnt = 0;
        r.ok = match;
        r.w0 = held_word[0];
        r.w1 = held_word[1];
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // offer one item, hold it until taken, then run the model on it
  task automatic send_byte(input logic [7:0] b, input bit use_typed, input res_t typed);
    res_t r;
    // random gaps, except in quiet stretches
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (deframe_byte(b, r)) pending_results.push_back(use_typed ? typed : r);
  endtask

  // frame with random records under the current head and start values
  task automatic send_frame(input bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = head_cfg + start_cfg;
    send_byte(head_cfg, 1'b0, '0);
    send_byte(start_cfg, 1'b0, '0);
    for (int i = 0; i < 10; i++) begin
      if (i % 5 == 0) begin
        // mostly real slot ids, now and then an out-of-range one
        b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
      end else begin
        case ($urandom_range(0, 7))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom);
        endcase
      end
      sum = sum + b;
      send_byte(b, 1'b0, '0);
    end
    if (!good_sum) sum = sum + 8'($urandom_range(1, 255));
    send_byte(sum, 1'b0, '0);
  endtask

  // wait until every expected result is out, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] h, input logic [7:0] s);
    cfg_we <= 1'b1;
    cfg_index <= REG_HEAD;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= REG_START;
    cfg_data <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    head_cfg = h;
    start_cfg = s;
  endtask

  // result side: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: ok %b w0 %h w1 %h",
                                  frame_ok, word_zero, word_one));
      end else begin
        got_front = pending_results.pop_front();
        if (frame_ok !== got_front.ok)
          report_mismatch($sformatf("frame_ok got %b expected %b", frame_ok, got_front.ok));
        if (word_zero !== got_front.w0)
          report_mismatch($sformatf("word_zero got %h expected %h", word_zero, got_front.w0));
        if (word_one !== got_front.w1)
          report_mismatch($sformatf("word_one got %h expected %h", word_one, got_front.w1));
        results_checked++;
        if (got_front.ok) frames_matched++;
      end
    end
  end

  // input back-pressure seen while an item waits
  always @(posedge clk) begin
    if (in_valid && in_stall) in_stall_cycles++;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] b;
    int phase_start;
    int pick;

    // mismatching frame right after reset: nothing held yet
    typed_result[14] = '{ok: 1'b0, w0: 32'h0, w1: 32'h0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part on the reset register values
    for (int i = 0; i < DIR_LEN; i++) begin
      idle_en = (i % 8) >= 4;
      send_byte(DIR_BYTES[i], (typed_result.exists(i) != 0),
                (typed_result.exists(i) != 0) ? typed_result[i] : '0);
    end

    // random part, one register setting per phase
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      drain_results();
      case (p)
        0: begin h = HEAD_RESET; s = START_RESET; end
        1: begin h = 8'h00; s = 8'hFF; end
        2: begin h = 8'hFF; s = 8'hFF; end
        3: begin h = 8'h00; s = 8'h00; end
        4: begin h = 8'hA5; s = 8'h5A; end
        default: begin h = 8'($urandom); s = 8'($urandom); end
      endcase
      write_regs(h, s);
      // long result-side hold-off while frames keep coming
      if (p == 1) hold_req = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        // last setting runs with no idling at all
        idle_en = (p != NUM_SETTINGS - 1) && ((bytes_sent % 128) >= 40);
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          send_frame(1'b1);
        end else if (pick < 16) begin
          send_frame(1'b0);
        end else if (pick < 18) begin
          // head followed by a wrong start byte
          b = 8'($urandom);
          if (b == start_cfg) b = ~b;
          send_byte(head_cfg, 1'b0, '0);
          send_byte(b, 1'b0, '0);
        end else begin
          // line noise
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0, '0);
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("sent %0d bytes under %0d register settings plus the reset values",
             bytes_sent, NUM_SETTINGS);
    $display("checked %0d frame results, %0d with a matching checksum; input held off %0d cycles",
             results_checked, frames_matched, in_stall_cycles);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: checksum_frame_receiver_top.f
rtl/cfr_pkg.sv
rtl/cfr_core.sv
rtl/cfr_out_buf.sv
rtl/checksum_frame_receiver_top.sv
rtl/cfr_checker.sv
tb/sv/checksum_frame_receiver_top_test.sv
